>>> rtl/sat_pkg.sv
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types and codes for the sampled allocation tracker.
// ----------------------------------------------------------------------------
package sat_pkg;

	localparam int ADDR_W = 32;

	// request codes
	localparam logic [2:0] REQ_ALLOC   = 3'd0;
	localparam logic [2:0] REQ_REALLOC = 3'd1;
	localparam logic [2:0] REQ_FREE    = 3'd2;
	localparam logic [2:0] REQ_EPOCH   = 3'd3;
	localparam logic [2:0] REQ_READ    = 3'd4;

	// result status codes
	localparam logic [1:0] ST_NONE    = 2'd0;
	localparam logic [1:0] ST_RECORD  = 2'd1;
	localparam logic [1:0] ST_DROPPED = 2'd2;

	// register indexes
	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_SHIFT     = 1'b1;

	localparam logic [31:0] THRESHOLD_RST = 32'd65536;
	localparam logic [4:0]  SHIFT_RST     = 5'd10;

	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] size;
		logic [31:0] birth;
		logic [31:0] caller;
	} entry_t;

	// controller -> datapath strobes
	typedef struct packed {
		logic clr;          // clear entry at idx, idx++
		logic load;         // capture item, update counters
		logic start_old;    // idx = home(old), cnt = 0
		logic start_res;    // idx = home(result), cnt = 0
		logic step;         // idx++, cnt++
		logic keep_old;     // old entry found at idx
		logic sel;          // sampling decision
		logic erase_start;  // idx = hole+1, cnt = 0
		logic erase_step;   // shift entry at idx into hole if allowed, idx++
		logic erase_end;    // empty the final hole
		logic write_new;    // store new entry at idx
		logic drop;         // table full
		logic rd_slot;      // read slot index
		logic slot_out;     // latch read slot contents
		logic result;       // load output registers
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic [2:0] req;
		logic       old_nz;
		logic       res_nz;
		logic       remove_ok;
		logic       selected;
		logic       rd_match;   // slot read holds the result address
		logic       rd_old;     // slot read holds the old address
		logic       rd_empty;
		logic       cnt_last;
		logic       clr_done;
	} stat_t;

endpackage

>>> rtl/sampled_allocation_tracker.sv
// Steps: set_epoch goes straight to the result, read_slot reads one slot;
//   alloc/realloc/free probe slots, and may scan more in the backward shift.
// Throughput: one item at a time; the next item is taken once the current
//   one has reached the result register (a pending result may still wait).
// Reset: arst_n clears control; a clearing pass then empties every slot
//   of the slot table, with in_ready low; config writes are taken.
// ----------------------------------------------------------------------------
// sampled_allocation_tracker
// Tracks sampled live allocations in a linear-probing hash table with
// backward-shift delete; APB-style register port for threshold and shift.
// ----------------------------------------------------------------------------
module sampled_allocation_tracker #(
	parameter int TABLE_SLOTS = 32768,
	parameter int HASH_SHIFT  = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB-style register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// item input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [31:0] old_address,
	input  logic [31:0] request_size,
	input  logic [31:0] result_address,
	input  logic [31:0] caller,
	input  logic [31:0] epoch_value,
	input  logic [14:0] slot_index,
	// result output
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        removed,
	output logic [31:0] slot_addr_out,
	output logic [31:0] slot_size_out,
	output logic [31:0] slot_birth_out,
	output logic [31:0] slot_caller_out,
	output logic [31:0] alloc_count,
	output logic [31:0] free_count,
	output logic [31:0] realloc_count,
	output logic [31:0] drop_count
);
	import sat_pkg::*;

	logic [31:0] threshold_q;
	logic [4:0]  shift_q;
	cmd_t        cmd;
	stat_t       stat;

	// registers sit at byte 0 (threshold) and 4 (shift)
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			shift_q     <= SHIFT_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_THRESHOLD: threshold_q <= pwdata;
				REG_SHIFT:     shift_q     <= pwdata[4:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_THRESHOLD: prdata = threshold_q;
			REG_SHIFT:     prdata = {27'd0, shift_q};
			default:       prdata = '0;
		endcase
	end

	sat_dp #(
		.TABLE_SLOTS(TABLE_SLOTS),
		.HASH_SHIFT (HASH_SHIFT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.large_threshold(threshold_q),
		.sample_shift   (shift_q),
		.req_type       (req_type),
		.old_address    (old_address),
		.request_size   (request_size),
		.result_address (result_address),
		.caller         (caller),
		.epoch_value    (epoch_value),
		.slot_index     (slot_index),
		.status         (status),
		.removed        (removed),
		.slot_addr_out  (slot_addr_out),
		.slot_size_out  (slot_size_out),
		.slot_birth_out (slot_birth_out),
		.slot_caller_out(slot_caller_out),
		.alloc_count    (alloc_count),
		.free_count     (free_count),
		.realloc_count  (realloc_count),
		.drop_count     (drop_count)
	);

	sat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

endmodule

>>> rtl/sat_dp.sv
// ----------------------------------------------------------------------------
// sat_dp
// Datapath: slot memory, probe/erase pointers, counters and result registers.
// ----------------------------------------------------------------------------
module sat_dp #(
	parameter int TABLE_SLOTS = 32768,
	parameter int HASH_SHIFT  = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sat_pkg::cmd_t     cmd,
	output sat_pkg::stat_t    stat,
	input  logic [31:0]       large_threshold,
	input  logic [4:0]        sample_shift,
	input  logic [2:0]        req_type,
	input  logic [31:0]       old_address,
	input  logic [31:0]       request_size,
	input  logic [31:0]       result_address,
	input  logic [31:0]       caller,
	input  logic [31:0]       epoch_value,
	input  logic [14:0]       slot_index,
	output logic [1:0]        status,
	output logic              removed,
	output logic [31:0]       slot_addr_out,
	output logic [31:0]       slot_size_out,
	output logic [31:0]       slot_birth_out,
	output logic [31:0]       slot_caller_out,
	output logic [31:0]       alloc_count,
	output logic [31:0]       free_count,
	output logic [31:0]       realloc_count,
	output logic [31:0]       drop_count
);
	import sat_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SLOTS);

	entry_t mem_q [TABLE_SLOTS];
	entry_t rd_q;

	logic [2:0]       req_q;
	logic [31:0]      old_q, size_q, res_q;
	logic [IDX_W-1:0] sidx_q;
	logic [IDX_W-1:0] idx_q, cnt_q, hole_q;
	logic [31:0]      birth_q, who_q;
	logic             found_q, selected_q, removed_q;
	logic [1:0]       status_q;
	logic [31:0]      seq_q, epoch_q;
	logic [31:0]      n_alloc_q, n_free_q, n_realloc_q, n_drop_q;
	entry_t           slot_q;

	logic             we;
	logic [IDX_W-1:0] wa, ra;
	entry_t           wd;
	logic [31:0]      seq_next, period_mask;
	logic [IDX_W-1:0] rd_dist, hole_dist;
	logic             move_ok;

	function automatic logic [IDX_W-1:0] home_of(input logic [31:0] a);
		return IDX_W'(a >> HASH_SHIFT);
	endfunction

	assign period_mask = (32'd1 << sample_shift) - 32'd1;
	assign seq_next    = seq_q + 32'd1;
	assign rd_dist     = idx_q - home_of(rd_q.addr);
	assign hole_dist   = idx_q - hole_q;
	assign move_ok     = rd_dist >= hole_dist;

	always_comb begin
		we = 1'b0;
		wa = idx_q;
		wd = rd_q;
		if (cmd.clr) begin
			we = 1'b1;
			wd = '0;
		end else if (cmd.erase_step && move_ok && rd_q.addr != '0) begin
			we = 1'b1;
			wa = hole_q;
		end else if (cmd.erase_end) begin
			we = 1'b1;
			wa = hole_q;
			wd.addr = '0;
		end else if (cmd.write_new) begin
			we = 1'b1;
			wd = '{addr: res_q, size: size_q, birth: birth_q, caller: who_q};
		end
		ra = cmd.rd_slot ? sidx_q : idx_q;
	end

	// slot memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rd_q <= mem_q[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			seq_q       <= '0;
			epoch_q     <= '0;
			n_alloc_q   <= '0;
			n_free_q    <= '0;
			n_realloc_q <= '0;
			n_drop_q    <= '0;
		end else begin
			if (cmd.clr || cmd.step || cmd.erase_step) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.start_old) begin
				idx_q <= home_of(old_q);
			end
			if (cmd.start_res) begin
				idx_q <= home_of(res_q);
			end
			if (cmd.erase_start) begin
				idx_q <= hole_q + 1'b1;
			end
			if (cmd.load) begin
				case (req_type)
					REQ_ALLOC:   n_alloc_q   <= n_alloc_q + 32'd1;
					REQ_REALLOC: n_realloc_q <= n_realloc_q + 32'd1;
					REQ_FREE:    n_free_q    <= n_free_q + 32'd1;
					REQ_EPOCH:   epoch_q     <= epoch_value;
					default:     ;
				endcase
			end
			if (cmd.sel && !found_q && size_q < large_threshold) begin
				seq_q <= seq_next;
			end
			if (cmd.drop) begin
				n_drop_q <= n_drop_q + 32'd1;
			end
		end
	end

	// item registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q      <= req_type;
			old_q      <= (req_type == REQ_ALLOC) ? 32'd0 : old_address;
			size_q     <= request_size;
			res_q      <= result_address;
			sidx_q     <= IDX_W'(slot_index);
			birth_q    <= epoch_q;
			who_q      <= caller;
			found_q    <= 1'b0;
			selected_q <= 1'b0;
			removed_q  <= 1'b0;
			status_q   <= ST_NONE;
			slot_q     <= '0;
		end
		if (cmd.start_old || cmd.start_res || cmd.erase_start) begin
			cnt_q <= '0;
		end
		if (cmd.step || cmd.erase_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.keep_old) begin
			hole_q  <= idx_q;
			found_q <= 1'b1;
			birth_q <= rd_q.birth;
			who_q   <= rd_q.caller;
		end
		if (cmd.erase_step && move_ok && rd_q.addr != '0) begin
			hole_q <= idx_q;
		end
		if (cmd.erase_start) begin
			removed_q <= 1'b1;
		end
		if (cmd.sel) begin
			selected_q <= found_q || size_q >= large_threshold ||
				(seq_next & period_mask) == '0;
		end
		if (cmd.write_new) begin
			status_q <= ST_RECORD;
		end
		if (cmd.drop) begin
			status_q <= ST_DROPPED;
		end
		if (cmd.slot_out && rd_q.addr != '0) begin
			slot_q <= rd_q;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.result) begin
			status          <= status_q;
			removed         <= removed_q;
			slot_addr_out   <= slot_q.addr;
			slot_size_out   <= slot_q.size;
			slot_birth_out  <= slot_q.birth;
			slot_caller_out <= slot_q.caller;
			alloc_count     <= n_alloc_q;
			free_count      <= n_free_q;
			realloc_count   <= n_realloc_q;
			drop_count      <= n_drop_q;
		end
	end

	always_comb begin
		stat.req       = req_q;
		stat.old_nz    = old_q != '0;
		stat.res_nz    = res_q != '0;
		stat.remove_ok = found_q && (res_q != '0 || size_q == '0);
		stat.selected  = selected_q;
		stat.rd_match  = rd_q.addr == res_q;
		stat.rd_old    = rd_q.addr == old_q;
		stat.rd_empty  = rd_q.addr == '0;
		stat.cnt_last  = &cnt_q;
		stat.clr_done  = &idx_q;
	end

endmodule

>>> rtl/sat_ctrl.sv
// ----------------------------------------------------------------------------
// sat_ctrl
// Sequencer: clearing pass, probe, backward-shift erase and result handshake.
// ----------------------------------------------------------------------------
module sat_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  sat_pkg::stat_t   stat,
	output sat_pkg::cmd_t    cmd
);
	import sat_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DISPATCH, S_P_RD, S_P_EV, S_SELECT, S_REMOVE,
		S_E_START, S_E_CHK, S_E_EV, S_E_END, S_NEWREC, S_RS_RD, S_RS_EV, S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   res_phase_q, res_phase_d;
	logic   out_valid_q;
	logic   match;

	// old probe compares against the old address, result probe against result
	assign match = res_phase_q ? stat.rd_match : stat.rd_old;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		res_phase_d = res_phase_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (stat.req)
					REQ_ALLOC: state_d = S_SELECT;
					REQ_REALLOC, REQ_FREE: begin
						if (stat.old_nz) begin
							cmd.start_old = 1'b1;
							res_phase_d   = 1'b0;
							state_d       = S_P_RD;
						end else begin
							state_d = (stat.req == REQ_FREE) ? S_DONE : S_SELECT;
						end
					end
					REQ_READ: state_d = S_RS_RD;
					default:  state_d = S_DONE;
				endcase
			end
			S_P_RD: state_d = S_P_EV;
			S_P_EV: begin
				if (res_phase_q) begin
					if (match || stat.rd_empty) begin
						cmd.write_new = 1'b1;
						state_d       = S_DONE;
					end else if (stat.cnt_last) begin
						cmd.drop = 1'b1;
						state_d  = S_DONE;
					end else begin
						cmd.step = 1'b1;
						state_d  = S_P_RD;
					end
				end else begin
					if (match) begin
						cmd.keep_old = 1'b1;
						state_d = (stat.req == REQ_FREE) ? S_E_START : S_SELECT;
					end else if (stat.rd_empty || stat.cnt_last) begin
						state_d = (stat.req == REQ_FREE) ? S_DONE : S_SELECT;
					end else begin
						cmd.step = 1'b1;
						state_d  = S_P_RD;
					end
				end
			end
			S_SELECT: begin
				cmd.sel = 1'b1;
				state_d = S_REMOVE;
			end
			S_REMOVE: state_d = stat.remove_ok ? S_E_START : S_NEWREC;
			S_E_START: begin
				cmd.erase_start = 1'b1;
				state_d         = S_E_CHK;
			end
			S_E_CHK: state_d = stat.cnt_last ? S_E_END : S_E_EV;
			S_E_EV: begin
				if (stat.rd_empty) begin
					state_d = S_E_END;
				end else begin
					cmd.erase_step = 1'b1;
					state_d        = S_E_CHK;
				end
			end
			S_E_END: begin
				cmd.erase_end = 1'b1;
				state_d = (stat.req == REQ_FREE) ? S_DONE : S_NEWREC;
			end
			S_NEWREC: begin
				if (stat.res_nz && stat.selected) begin
					cmd.start_res = 1'b1;
					res_phase_d   = 1'b1;
					state_d       = S_P_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_RS_RD: begin
				cmd.rd_slot = 1'b1;
				state_d     = S_RS_EV;
			end
			S_RS_EV: begin
				cmd.slot_out = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.result = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			res_phase_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_phase_q <= res_phase_d;
			if (cmd.result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
